### hdl/fea_pkg.sv
// Package for the free extent allocator: widths, status, function and CSR codes,
// sequencer state type. No dependencies.
package fea_pkg;
   localparam int TableEntries = 64;
   localparam int AddrWidth    = 16;
   localparam int CsrIdxWidth  = 2;
   localparam int CsrDataWidth = 16;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_NOFIT = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic [CsrIdxWidth-1:0] CSR_FIT_MODE    = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_REGION_BASE = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_REGION_SIZE = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN,
      S_ALLOC_UPD,
      S_FREE_DEC,
      S_SHIFT_DN_RD,
      S_SHIFT_DN_WR,
      S_SHIFT_UP_RD,
      S_SHIFT_UP_WR,
      S_INS_WR,
      S_MERGE_NEXT,
      S_RESP
   } state_type;
endpackage

### hdl/fea_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module fea_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

### hdl/free_extent_allocator_core.sv
// Free extent allocator top level: sequencer over one table RAM.
// Depends on fea_pkg and fea_ram.
// Each stored extent is scanned by a read state and a compare state; removal or insertion
// then moves entries one at a time, each by a read and a write through the single RAM port.
// One item at a time; req_tready is low while busy or a result waits.
// Reset clears the count, state, valid flag and CSR registers (empty table); no clearing pass is needed.
module free_extent_allocator_core #(
   parameter int TableEntries = fea_pkg::TableEntries
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // block_size[15:0], block_addr[31:16]
   input  logic        req_tuser,  // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // granted_addr[15:0], status[17:16], zero fill
   input  logic        csr_wr_en,
   input  logic [fea_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [fea_pkg::CsrDataWidth-1:0] csr_wr_data
);
   localparam int AddrWidth = fea_pkg::AddrWidth;
   localparam int IW = $clog2(TableEntries);
   localparam int CW = $clog2(TableEntries + 1);
   localparam int EW = 2 * AddrWidth;

   fea_pkg::state_type state_ff, state_in;

   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        idx_ff, idx_in;     // scan / shift pointer
   logic [CW-1:0]        pick_ff, pick_in;   // chosen / insertion index
   logic                 found_ff, found_in;
   logic [AddrWidth-1:0] best_ff, best_in;
   logic                 func_ff;
   logic [AddrWidth-1:0] size_ff, addr_ff;
   logic                 fit_ff;
   logic [AddrWidth-1:0] gaddr_ff, gaddr_in;
   logic [1:0]           status_ff, status_in;
   logic                 rvalid_ff, rvalid_in;
   // previous entry seen during a free scan
   logic                 prev_ok_ff, prev_ok_in;
   logic [AddrWidth-1:0] prev_b_ff, prev_b_in, prev_l_ff, prev_l_in;
   logic [AddrWidth-1:0] hold_b_ff, hold_b_in, hold_l_ff, hold_l_in;
   logic [AddrWidth-1:0] rbase_ff, rsize_ff;

   logic          ram_we;
   logic [IW-1:0] ram_addr;
   logic [EW-1:0] ram_wdata, ram_rdata;
   logic [AddrWidth-1:0] rd_b, rd_l, end_a;

   fea_ram #(.Width(EW), .Depth(TableEntries)) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   assign rd_b  = ram_rdata[AddrWidth-1:0];
   assign rd_l  = ram_rdata[EW-1:AddrWidth];
   assign end_a = addr_ff + size_ff;

   assign req_tready = (state_ff == fea_pkg::S_IDLE) && !rvalid_ff;
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = {6'd0, status_ff, gaddr_ff[15:0]};

   logic accept;
   assign accept = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fea_pkg::S_IDLE: begin
            if (accept) begin
               if (req_tuser == fea_pkg::FUNC_FREE && req_tdata[15:0] == 16'd0) begin
                  state_in = fea_pkg::S_RESP;
               end else begin
                  state_in = fea_pkg::S_SCAN_RD;
               end
            end
         end
         fea_pkg::S_SCAN_RD: begin
            state_in = (idx_ff < count_ff) ? fea_pkg::S_SCAN
                     : (func_ff == fea_pkg::FUNC_FREE) ? fea_pkg::S_FREE_DEC
                     : fea_pkg::S_ALLOC_UPD;
         end
         fea_pkg::S_SCAN: begin
            if (func_ff == fea_pkg::FUNC_FREE && rd_b > addr_ff) begin
               state_in = fea_pkg::S_FREE_DEC;
            end else begin
               state_in = fea_pkg::S_SCAN_RD;
            end
         end
         fea_pkg::S_ALLOC_UPD: begin
            if (!found_ff) begin
               state_in = fea_pkg::S_RESP;
            end else if (rd_l == size_ff) begin
               state_in = fea_pkg::S_SHIFT_DN_RD;
            end else begin
               state_in = fea_pkg::S_RESP;
            end
         end
         fea_pkg::S_FREE_DEC: begin
            if (prev_ok_ff && (prev_b_ff + prev_l_ff) == addr_ff) begin
               state_in = (found_ff && end_a == hold_b_ff) ? fea_pkg::S_MERGE_NEXT
                                                           : fea_pkg::S_RESP;
            end else if (found_ff && end_a == hold_b_ff) begin
               state_in = fea_pkg::S_RESP;
            end else if (count_ff >= CW'(TableEntries)) begin
               state_in = fea_pkg::S_RESP;
            end else begin
               state_in = fea_pkg::S_SHIFT_UP_RD;
            end
         end
         fea_pkg::S_MERGE_NEXT:  state_in = fea_pkg::S_SHIFT_DN_RD;
         fea_pkg::S_SHIFT_DN_RD: state_in = (idx_ff + CW'(1) < count_ff)
                                            ? fea_pkg::S_SHIFT_DN_WR : fea_pkg::S_RESP;
         fea_pkg::S_SHIFT_DN_WR: state_in = fea_pkg::S_SHIFT_DN_RD;
         fea_pkg::S_SHIFT_UP_RD: state_in = (idx_ff > pick_ff)
                                            ? fea_pkg::S_SHIFT_UP_WR : fea_pkg::S_INS_WR;
         fea_pkg::S_SHIFT_UP_WR: state_in = fea_pkg::S_SHIFT_UP_RD;
         fea_pkg::S_INS_WR:      state_in = fea_pkg::S_RESP;
         fea_pkg::S_RESP:        state_in = fea_pkg::S_IDLE;
         default:                state_in = fea_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      count_in   = count_ff;
      idx_in     = idx_ff;
      pick_in    = pick_ff;
      found_in   = found_ff;
      best_in    = best_ff;
      gaddr_in   = gaddr_ff;
      status_in  = status_ff;
      rvalid_in  = rvalid_ff;
      prev_ok_in = prev_ok_ff;
      prev_b_in  = prev_b_ff;
      prev_l_in  = prev_l_ff;
      hold_b_in  = hold_b_ff;
      hold_l_in  = hold_l_ff;
      ram_we     = 1'b0;
      ram_addr   = idx_ff[IW-1:0];
      ram_wdata  = {hold_l_ff, hold_b_ff};
      if (rvalid_ff && rsp_tready) begin
         rvalid_in = 1'b0;
      end
      unique case (state_ff)
         fea_pkg::S_IDLE: begin
            // keep the waiting result intact until a new item arrives
            if (accept) begin
               idx_in     = '0;
               found_in   = 1'b0;
               prev_ok_in = 1'b0;
               gaddr_in   = '0;
               status_in  = fea_pkg::ST_DONE;
            end
         end
         fea_pkg::S_SCAN_RD: begin
            ram_addr = idx_ff[IW-1:0];
            if (idx_ff >= count_ff) begin
               ram_addr = pick_ff[IW-1:0];
               if (func_ff == fea_pkg::FUNC_FREE) begin
                  pick_in = idx_ff;
               end
            end
         end
         fea_pkg::S_SCAN: begin
            if (func_ff == fea_pkg::FUNC_ALLOC) begin
               if (rd_l >= size_ff &&
                   (!found_ff || (fit_ff ? (rd_l > best_ff) : (rd_l < best_ff)))) begin
                  found_in = 1'b1;
                  pick_in  = idx_ff;
                  best_in  = rd_l;
               end
               idx_in = idx_ff + CW'(1);
            end else if (rd_b > addr_ff) begin
               found_in  = 1'b1;
               pick_in   = idx_ff;
               hold_b_in = rd_b;
               hold_l_in = rd_l;
            end else begin
               prev_ok_in = 1'b1;
               prev_b_in  = rd_b;
               prev_l_in  = rd_l;
               idx_in     = idx_ff + CW'(1);
            end
         end
         fea_pkg::S_ALLOC_UPD: begin
            if (!found_ff) begin
               status_in = fea_pkg::ST_NOFIT;
            end else begin
               gaddr_in  = rd_b;
               ram_we    = 1'b1;
               ram_addr  = pick_ff[IW-1:0];
               ram_wdata = {rd_l - size_ff, rd_b + size_ff};
               idx_in    = pick_ff;
            end
         end
         fea_pkg::S_FREE_DEC: begin
            // pick_ff is the first entry with base above the block, or the count if there is none
            if (prev_ok_ff && (prev_b_ff + prev_l_ff) == addr_ff) begin
               ram_we    = 1'b1;
               ram_addr  = IW'(pick_ff - CW'(1));
               prev_l_in = prev_l_ff + size_ff;
               ram_wdata = {prev_l_ff + size_ff, prev_b_ff};
               idx_in    = pick_ff;
            end else if (found_ff && end_a == hold_b_ff) begin
               ram_we    = 1'b1;
               ram_addr  = pick_ff[IW-1:0];
               ram_wdata = {hold_l_ff + size_ff, hold_b_ff - size_ff};
            end else if (count_ff >= CW'(TableEntries)) begin
               status_in = fea_pkg::ST_FULL;
            end else begin
               idx_in = count_ff;
            end
         end
         fea_pkg::S_MERGE_NEXT: begin
            ram_we    = 1'b1;
            ram_addr  = IW'(pick_ff - CW'(1));
            ram_wdata = {prev_l_ff + hold_l_ff, prev_b_ff};
         end
         fea_pkg::S_SHIFT_DN_RD: begin
            ram_addr = IW'(idx_ff + CW'(1));
            if (idx_ff + CW'(1) >= count_ff) begin
               count_in = count_ff - CW'(1);
            end
         end
         fea_pkg::S_SHIFT_DN_WR: begin
            ram_we    = 1'b1;
            ram_addr  = idx_ff[IW-1:0];
            ram_wdata = ram_rdata;
            idx_in    = idx_ff + CW'(1);
         end
         fea_pkg::S_SHIFT_UP_RD: begin
            ram_addr = IW'(idx_ff - CW'(1));
         end
         fea_pkg::S_SHIFT_UP_WR: begin
            ram_we    = 1'b1;
            ram_addr  = idx_ff[IW-1:0];
            ram_wdata = ram_rdata;
            idx_in    = idx_ff - CW'(1);
         end
         fea_pkg::S_INS_WR: begin
            ram_we    = 1'b1;
            ram_addr  = pick_ff[IW-1:0];
            ram_wdata = {size_ff, addr_ff};
            count_in  = count_ff + CW'(1);
         end
         fea_pkg::S_RESP: begin
            rvalid_in = 1'b1;
         end
         default: ;
      endcase
      // region reload: single extent in entry 0
      if (csr_wr_en && (csr_index == fea_pkg::CSR_REGION_BASE ||
                        csr_index == fea_pkg::CSR_REGION_SIZE)) begin
         ram_we    = 1'b1;
         ram_addr  = '0;
         if (csr_index == fea_pkg::CSR_REGION_BASE) begin
            ram_wdata = {rsize_ff, AddrWidth'(csr_wr_data)};
            count_in  = (rsize_ff != '0) ? CW'(1) : '0;
         end else begin
            ram_wdata = {AddrWidth'(csr_wr_data), rbase_ff};
            count_in  = (csr_wr_data != '0) ? CW'(1) : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= fea_pkg::S_IDLE;
         count_ff  <= '0;
         rvalid_ff <= 1'b0;
         fit_ff    <= 1'b0;
         rbase_ff  <= '0;
         rsize_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rvalid_ff <= rvalid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               fea_pkg::CSR_FIT_MODE:    fit_ff   <= csr_wr_data[0];
               fea_pkg::CSR_REGION_BASE: rbase_ff <= AddrWidth'(csr_wr_data);
               fea_pkg::CSR_REGION_SIZE: rsize_ff <= AddrWidth'(csr_wr_data);
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      pick_ff    <= pick_in;
      found_ff   <= found_in;
      best_ff    <= best_in;
      gaddr_ff   <= gaddr_in;
      status_ff  <= status_in;
      prev_ok_ff <= prev_ok_in;
      prev_b_ff  <= prev_b_in;
      prev_l_ff  <= prev_l_in;
      hold_b_ff  <= hold_b_in;
      hold_l_ff  <= hold_l_in;
      if (accept) begin
         func_ff <= req_tuser;
         size_ff <= AddrWidth'(req_tdata[15:0]);
         addr_ff <= AddrWidth'(req_tdata[31:16]);
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TableEntries)) else $error("extent count overflow");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rvalid_ff && !rsp_tready |=> rvalid_ff && $stable(rsp_tdata))
      else $error("result dropped");
   a_nofit_zero: assert property (@(posedge clock) disable iff (reset)
      rvalid_ff && status_ff != fea_pkg::ST_DONE |-> gaddr_ff == '0)
      else $error("failed item with nonzero address");
endmodule
